FILE: rtl/core/afd_pkg.sv
// Package for the API frame deframer.
// Holds the frame-format constants, register indexes and result codes.
// No dependencies.
package afd_pkg;

   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned POS_W   = 9;
   localparam int unsigned OFF_W   = 6;
   localparam int unsigned CSR_IDX_W = 3;

   localparam logic [BYTE_W-1:0] START_BYTE = 8'h7E;
   localparam logic [BYTE_W-1:0] SUM_GOOD   = 8'hFF;
   localparam logic [POS_W-1:0]  LEN_BIAS   = 9'd3;
   localparam logic [POS_W-1:0]  TYPE_POS   = 9'd3;
   localparam logic [POS_W-1:0]  LEN_POS    = 9'd2;
   localparam logic [POS_W-1:0]  FIRST_POS  = 9'd1;

   typedef logic [CSR_IDX_W-1:0] csr_index_type;

   localparam csr_index_type REG_TYPE_A_CODE   = 3'd0;
   localparam csr_index_type REG_TYPE_A_OFFSET = 3'd1;
   localparam csr_index_type REG_TYPE_B_CODE   = 3'd2;
   localparam csr_index_type REG_TYPE_B_OFFSET = 3'd3;
   localparam csr_index_type REG_PAYLOAD_LIMIT = 3'd4;

   typedef logic [1:0] result_kind_type;

   localparam result_kind_type KIND_PAYLOAD  = 2'd0;
   localparam result_kind_type KIND_SUM_GOOD = 2'd1;
   localparam result_kind_type KIND_SUM_BAD  = 2'd2;

   localparam logic [BYTE_W-1:0] RST_TYPE_A_CODE   = 8'd144;
   localparam logic [OFF_W-1:0]  RST_TYPE_A_OFFSET = 6'd14;
   localparam logic [BYTE_W-1:0] RST_TYPE_B_CODE   = 8'd173;
   localparam logic [OFF_W-1:0]  RST_TYPE_B_OFFSET = 6'd4;
   localparam logic [BYTE_W-1:0] RST_PAYLOAD_LIMIT = 8'd255;

endpackage

FILE: rtl/core/api_frame_deframer.sv
// API frame deframer, top level.
// Depends on afd_pkg for frame constants, register indexes and result codes.
//
// The deframer takes one received serial byte per transfer on the req_ channel
// and recognizes radio-module API frames: a 0x7E start byte always restarts a
// frame, the next two bytes carry the length (only the low byte is used), the
// fourth byte is the frame type and the last byte is an 8-bit checksum that
// makes the sum of all bytes from the frame type onward equal 0xFF. Two frame
// types are accepted, each with its own programmable header length; any other
// type abandons the frame without a result. Each payload byte comes out on the
// rsp_ channel as one transfer with its index, up to payload_limit bytes (and
// never more than PAYLOAD_DEPTH), and the checksum byte produces one status
// transfer with the good or bad verdict and the payload length. Bytes outside
// a frame and header bytes produce nothing. The block accepts one byte every
// clock cycle: all decoding is done in a single pass from the accepted byte
// and the frame state registers into the result register, so the result of an
// accepted byte shows on rsp_ in the next cycle. req_ready stays high while the
// result register is empty or being drained in the same cycle, so only a
// stalled rsp_ channel slows the input. The csr_ port writes the five
// configuration registers and should only be used while no frame is in flight.
module api_frame_deframer #(
   parameter int unsigned PAYLOAD_DEPTH = 256
) (
   input  logic                            clock,
   input  logic                            reset,
   // Byte input channel.
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [afd_pkg::BYTE_W-1:0]      req_rx_byte,
   // Result channel.
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [1:0]                      rsp_kind,
   output logic [afd_pkg::BYTE_W-1:0]      rsp_data_byte,
   output logic [afd_pkg::BYTE_W-1:0]      rsp_byte_index,
   output logic                            rsp_frame_kind,
   // Configuration write port.
   input  logic                            csr_write_en,
   input  logic [afd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [afd_pkg::BYTE_W-1:0]      csr_wdata
);

   import afd_pkg::*;

   // Wide enough for the overlong-frame limit, which can exceed the position range.
   localparam int unsigned LIM_W = POS_W + 1;
   localparam logic [LIM_W-1:0] DepthLimit = LIM_W'(PAYLOAD_DEPTH);

   // Configuration registers.
   logic [BYTE_W-1:0] type_a_code_ff;
   logic [OFF_W-1:0]  type_a_offset_ff;
   logic [BYTE_W-1:0] type_b_code_ff;
   logic [OFF_W-1:0]  type_b_offset_ff;
   logic [BYTE_W-1:0] payload_limit_ff;

   // Frame state.
   logic              in_frame_ff,  in_frame_in;
   logic [POS_W-1:0]  position_ff,  position_in;
   logic [POS_W-1:0]  frame_end_ff, frame_end_in;
   logic [OFF_W-1:0]  offset_ff,    offset_in;
   logic              kind_sel_ff,  kind_sel_in;
   logic [BYTE_W-1:0] sum_ff,       sum_in;

   // Result register.
   logic              rsp_valid_ff, rsp_valid_in;
   result_kind_type   rsp_kind_ff,  rsp_kind_in;
   logic [BYTE_W-1:0] rsp_data_ff,  rsp_data_in;
   logic [BYTE_W-1:0] rsp_index_ff, rsp_index_in;
   logic              rsp_fkind_ff, rsp_fkind_in;

   logic              req_take;
   logic              res_fire;
   logic [OFF_W-1:0]  off_cur;
   logic [POS_W-1:0]  idx;
   logic [POS_W-1:0]  pos_inc;
   logic [LIM_W-1:0]  overlong_lim;

   // A new byte can enter whenever the result register is free this cycle.
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_take  = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         type_a_code_ff   <= RST_TYPE_A_CODE;
         type_a_offset_ff <= RST_TYPE_A_OFFSET;
         type_b_code_ff   <= RST_TYPE_B_CODE;
         type_b_offset_ff <= RST_TYPE_B_OFFSET;
         payload_limit_ff <= RST_PAYLOAD_LIMIT;
      end else if (csr_write_en) begin
         case (csr_index)
            REG_TYPE_A_CODE:   type_a_code_ff   <= csr_wdata;
            REG_TYPE_A_OFFSET: type_a_offset_ff <= csr_wdata[OFF_W-1:0];
            REG_TYPE_B_CODE:   type_b_code_ff   <= csr_wdata;
            REG_TYPE_B_OFFSET: type_b_offset_ff <= csr_wdata[OFF_W-1:0];
            REG_PAYLOAD_LIMIT: payload_limit_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Frame decoding: one accepted byte updates the frame state and may load
   // one result.
   always_comb begin
      in_frame_in  = in_frame_ff;
      position_in  = position_ff;
      frame_end_in = frame_end_ff;
      offset_in    = offset_ff;
      kind_sel_in  = kind_sel_ff;
      sum_in       = sum_ff;
      res_fire     = 1'b0;
      rsp_kind_in  = KIND_PAYLOAD;
      rsp_data_in  = '0;
      rsp_index_in = '0;
      rsp_fkind_in = kind_sel_ff;

      // The offset in force for this byte; the type byte selects a new one.
      off_cur = offset_ff;
      if (position_ff == TYPE_POS) begin
         off_cur = (req_rx_byte == type_a_code_ff) ? type_a_offset_ff : type_b_offset_ff;
      end
      idx          = position_ff - POS_W'(off_cur) - FIRST_POS;
      pos_inc      = position_ff + FIRST_POS;
      overlong_lim = DepthLimit + LIM_W'(off_cur) + LIM_W'(2);

      if (req_take) begin
         if (req_rx_byte == START_BYTE) begin
            in_frame_in = 1'b1;
            position_in = FIRST_POS;
            sum_in      = '0;
         end else if (in_frame_ff) begin
            if (position_ff >= TYPE_POS) begin
               sum_in = sum_ff + req_rx_byte;
            end
            if (position_ff == TYPE_POS && req_rx_byte != type_a_code_ff
                && req_rx_byte != type_b_code_ff) begin
               // Unknown frame type: drop the frame quietly.
               in_frame_in = 1'b0;
               position_in = '0;
            end else begin
               if (position_ff == LEN_POS) begin
                  frame_end_in = POS_W'(req_rx_byte) + LEN_BIAS;
               end
               if (position_ff == TYPE_POS) begin
                  offset_in   = off_cur;
                  kind_sel_in = (req_rx_byte != type_a_code_ff);
               end
               rsp_fkind_in = kind_sel_in;
               position_in  = pos_inc;
               if (position_ff >= TYPE_POS && POS_W'(off_cur) < position_ff
                   && position_ff >= frame_end_ff) begin
                  // Checksum byte: report the verdict and the payload length.
                  res_fire     = 1'b1;
                  rsp_kind_in  = (sum_in == SUM_GOOD) ? KIND_SUM_GOOD : KIND_SUM_BAD;
                  rsp_index_in = (idx[POS_W-1]) ? '1 : idx[BYTE_W-1:0];
                  in_frame_in  = 1'b0;
                  position_in  = '0;
               end else begin
                  if (position_ff >= TYPE_POS && POS_W'(off_cur) < position_ff
                      && idx < POS_W'(payload_limit_ff)
                      && LIM_W'(idx) < DepthLimit) begin
                     res_fire     = 1'b1;
                     rsp_data_in  = req_rx_byte;
                     rsp_index_in = idx[BYTE_W-1:0];
                  end
                  // A frame that runs past the payload store is abandoned.
                  if (LIM_W'(pos_inc) >= overlong_lim) begin
                     in_frame_in = 1'b0;
                     position_in = '0;
                  end
               end
            end
         end
      end

      rsp_valid_in = res_fire || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff  <= 1'b0;
         position_ff  <= '0;
         frame_end_ff <= '0;
         offset_ff    <= RST_TYPE_A_OFFSET;
         kind_sel_ff  <= 1'b0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_frame_ff  <= in_frame_in;
         position_ff  <= position_in;
         frame_end_ff <= frame_end_in;
         offset_ff    <= offset_in;
         kind_sel_ff  <= kind_sel_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload only loads when a new result is produced.
   always_ff @(posedge clock) begin
      if (res_fire) begin
         rsp_kind_ff  <= rsp_kind_in;
         rsp_data_ff  <= rsp_data_in;
         rsp_index_ff <= rsp_index_in;
         rsp_fkind_ff <= rsp_fkind_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_kind       = rsp_kind_ff;
   assign rsp_data_byte  = rsp_data_ff;
   assign rsp_byte_index = rsp_index_ff;
   assign rsp_frame_kind = rsp_fkind_ff;

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for api_frame_deframer: directed and random byte streams with checks.
// Depends on afd_pkg and the api_frame_deframer RTL only.
module testbench;
   import afd_pkg::*;

   localparam int unsigned PAYLOAD_DEPTH = 256;
   // Cycles with no transfer on either channel before the run is declared hung.
   localparam int unsigned QUIET_LIMIT   = 1000;
   // The block answers a byte in the cycle after taking it; this leaves a safe margin.
   localparam int unsigned SETTLE_CYCLES = 4;
   localparam int unsigned IDLE_PERCENT  = 29;

   typedef struct packed {
      result_kind_type   kind;
      logic [BYTE_W-1:0] data_byte;
      logic [BYTE_W-1:0] byte_index;
      logic              frame_kind;
   } deframe_result_type;

   logic                clock;
   logic                reset        = 1'b1;
   logic                req_valid    = 1'b0;
   logic                req_ready;
   logic [BYTE_W-1:0]   req_rx_byte  = '0;
   logic                rsp_valid;
   logic                rsp_ready    = 1'b0;
   logic [1:0]          rsp_kind;
   logic [BYTE_W-1:0]   rsp_data_byte;
   logic [BYTE_W-1:0]   rsp_byte_index;
   logic                rsp_frame_kind;
   logic                csr_write_en = 1'b0;
   csr_index_type       csr_index    = '0;
   logic [BYTE_W-1:0]   csr_wdata    = '0;

   // Bytes waiting to be driven, and the results the byte stream should produce.
   logic [BYTE_W-1:0]   rx_stream[$];
   deframe_result_type  predicted_rsp[$];
   int unsigned         bytes_queued = 0;
   int unsigned         fail_count   = 0;
   int unsigned         quiet_cycles = 0;
   logic                byte_moved   = 1'b0;
   // When set, neither side inserts idle cycles.
   bit                  link_steady  = 1'b0;

   // Our copy of the configuration registers.
   logic [BYTE_W-1:0]   code_a      = RST_TYPE_A_CODE;
   logic [OFF_W-1:0]    off_a       = RST_TYPE_A_OFFSET;
   logic [BYTE_W-1:0]   code_b      = RST_TYPE_B_CODE;
   logic [OFF_W-1:0]    off_b       = RST_TYPE_B_OFFSET;
   logic [BYTE_W-1:0]   limit_bytes = RST_PAYLOAD_LIMIT;

   // Our copy of the frame tracking state.
   bit                  frame_open  = 1'b0;
   int unsigned         frame_pos   = 0;
   int unsigned         frame_last  = 0;
   int unsigned         frame_off   = RST_TYPE_A_OFFSET;
   logic                frame_sel   = 1'b0;
   logic [BYTE_W-1:0]   frame_sum   = '0;

   api_frame_deframer #(
      .PAYLOAD_DEPTH(PAYLOAD_DEPTH)
   ) u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_rx_byte    (req_rx_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_kind       (rsp_kind),
      .rsp_data_byte  (rsp_data_byte),
      .rsp_byte_index (rsp_byte_index),
      .rsp_frame_kind (rsp_frame_kind),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Walks one accepted byte through the frame state and queues the result it causes.
   function automatic void deframe_byte(input logic [BYTE_W-1:0] b);
      int unsigned        idx;
      deframe_result_type r;
      // A start byte restarts the frame no matter where we are.
      if (b == START_BYTE) begin
         frame_open = 1'b1;
         frame_pos  = FIRST_POS;
         frame_sum  = '0;
         return;
      end
      if (!frame_open)
         return;
      // The checksum covers the frame type and everything after it.
      if (frame_pos >= TYPE_POS)
         frame_sum = frame_sum + b;
      if (frame_pos == LEN_POS) begin
         frame_last = b + LEN_BIAS;
      end else if (frame_pos >= TYPE_POS) begin
         if (frame_pos == TYPE_POS) begin
            // Type A is checked first, so it wins when both codes are equal.
            if (b == code_a) begin
               frame_off = off_a;
               frame_sel = 1'b0;
            end else if (b == code_b) begin
               frame_off = off_b;
               frame_sel = 1'b1;
            end else begin
               frame_open = 1'b0;
               frame_pos  = 0;
               return;
            end
         end
         // With a header offset below three, the type byte itself is payload.
         if (frame_off < frame_pos) begin
            idx          = frame_pos - frame_off - 1;
            r.frame_kind = frame_sel;
            if (frame_pos >= frame_last) begin
               // Checksum byte: status with the payload length, saturated to a byte.
               r.kind       = (frame_sum == SUM_GOOD) ? KIND_SUM_GOOD : KIND_SUM_BAD;
               r.data_byte  = '0;
               r.byte_index = (idx > 255) ? 8'hFF : idx[BYTE_W-1:0];
               frame_open   = 1'b0;
               frame_pos    = 0;
               predicted_rsp.push_back(r);
               return;
            end
            // Payload past the limit or the buffer depth is consumed silently.
            if (idx < limit_bytes && idx < PAYLOAD_DEPTH) begin
               r.kind       = KIND_PAYLOAD;
               r.data_byte  = b;
               r.byte_index = idx[BYTE_W-1:0];
               predicted_rsp.push_back(r);
            end
         end
      end
      frame_pos = (frame_pos + 1) & 9'h1FF;
      // An overlong frame is dropped without a status.
      if (frame_pos >= PAYLOAD_DEPTH + frame_off + 2) begin
         frame_open = 1'b0;
         frame_pos  = 0;
      end
   endfunction

   task automatic check_field(input string name, input int unsigned want, input int unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         fail_count++;
      end
   endtask

   function automatic void push_byte(input logic [BYTE_W-1:0] v);
      rx_stream.push_back(v);
      bytes_queued++;
   endfunction

   // In clean frames a stray start byte in the content would cut the frame short.
   function automatic logic [BYTE_W-1:0] scrub(input logic [BYTE_W-1:0] v, input bit clean);
      return (clean && v == START_BYTE) ? START_BYTE - 8'd1 : v;
   endfunction

   // A frame type that matches neither configured code.
   function automatic logic [BYTE_W-1:0] stray_code();
      logic [BYTE_W-1:0] c;
      do
         c = 8'($urandom);
      while (c == code_a || c == code_b || c == START_BYTE);
      return c;
   endfunction

   // Queues one frame. The length byte counts the type byte and the content, so the
   // checksum sits at position len_lo + 3. A length of zero makes the type byte the
   // checksum byte for the block when the header offset is below three.
   function automatic void queue_frame(input logic [BYTE_W-1:0] type_code,
                                       input logic [BYTE_W-1:0] len_lo,
                                       input bit sum_ok, input bit clean);
      logic [BYTE_W-1:0] sum;
      logic [BYTE_W-1:0] body;
      if (clean && len_lo == START_BYTE)
         len_lo = len_lo - 8'd1;
      push_byte(START_BYTE);
      push_byte(scrub(8'($urandom), clean));
      push_byte(len_lo);
      push_byte(type_code);
      if (len_lo != 0) begin
         sum = type_code;
         repeat (len_lo - 1) begin
            body = scrub(8'($urandom), clean);
            push_byte(body);
            sum += body;
         end
         body = SUM_GOOD - sum;
         if (!sum_ok)
            body ^= 8'($urandom_range(1, 255));
         push_byte(body);
      end
   endfunction

   task automatic program_register(input csr_index_type index, input logic [BYTE_W-1:0] value);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= index;
      csr_wdata    <= value;
      case (index)
         REG_TYPE_A_CODE:   code_a      = value;
         REG_TYPE_A_OFFSET: off_a       = value[OFF_W-1:0];
         REG_TYPE_B_CODE:   code_b      = value;
         REG_TYPE_B_OFFSET: off_b       = value[OFF_W-1:0];
         REG_PAYLOAD_LIMIT: limit_bytes = value;
         default: ;
      endcase
      @(negedge clock);
      csr_write_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic program_all(input logic [BYTE_W-1:0] a_code, input logic [BYTE_W-1:0] a_off,
                              input logic [BYTE_W-1:0] b_code, input logic [BYTE_W-1:0] b_off,
                              input logic [BYTE_W-1:0] limit);
      program_register(REG_TYPE_A_CODE, a_code);
      program_register(REG_TYPE_A_OFFSET, a_off);
      program_register(REG_TYPE_B_CODE, b_code);
      program_register(REG_TYPE_B_OFFSET, b_off);
      program_register(REG_PAYLOAD_LIMIT, limit);
   endtask

   // Ends the phase with a frame of unknown type so no frame is in flight, then waits
   // until every byte has been taken and every result has arrived.
   task automatic close_phase();
      push_byte(START_BYTE);
      push_byte(8'h00);
      push_byte(8'h00);
      push_byte(stray_code());
      while (rx_stream.size() != 0 || req_valid || predicted_rsp.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Mostly well-formed frames of both kinds with random content and lengths, with some
   // unknown types, bad checksums, restarts and loose bytes mixed in.
   task automatic run_traffic(input int unsigned budget);
      int unsigned       stop_at;
      int unsigned       roll;
      logic [BYTE_W-1:0] type_code;
      logic [BYTE_W-1:0] len_lo;
      stop_at = bytes_queued + budget;
      while (bytes_queued < stop_at) begin
         roll = $urandom_range(0, 99);
         if (roll < 6) begin
            repeat ($urandom_range(1, 3)) push_byte(8'($urandom));
         end else begin
            roll = $urandom_range(0, 99);
            if (roll < 45)
               type_code = code_a;
            else if (roll < 90)
               type_code = code_b;
            else
               type_code = stray_code();
            // Short frames dominate; a few run to the full length byte range.
            roll = $urandom_range(0, 99);
            if (roll < 70)
               len_lo = 8'($urandom_range(0, 20));
            else if (roll < 95)
               len_lo = 8'($urandom_range(21, 80));
            else
               len_lo = 8'($urandom_range(81, 255));
            queue_frame(type_code, len_lo, $urandom_range(0, 99) < 85,
                        $urandom_range(0, 99) < 92);
         end
      end
      close_phase();
   endtask

   task automatic program_random();
      program_all(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      // Writes to unused indexes must leave every register alone.
      program_register(csr_index_type'($urandom_range(REG_PAYLOAD_LIMIT + 1,
                                                      2**CSR_IDX_W - 1)), 8'($urandom));
   endtask

   // Sender: starts a new transfer only once the previous one has been taken.
   always @(negedge clock) begin
      if (!reset && (!req_valid || byte_moved)) begin
         if (rx_stream.size() != 0 &&
             (link_steady || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
            req_valid   <= 1'b1;
            req_rx_byte <= rx_stream.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: stalls at random unless the link is in its steady stretch.
   always @(negedge clock) begin
      rsp_ready <= link_steady || $urandom_range(0, 99) >= IDLE_PERCENT;
   end

   // Results are checked before the byte taken at the same edge is predicted; the
   // block cannot answer a byte in the cycle it takes it.
   always @(posedge clock) begin : transfer_monitor
      deframe_result_type want;
      byte_moved <= req_valid && req_ready;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (predicted_rsp.size() == 0) begin
               $error("unexpected result: kind %0d data_byte %0d byte_index %0d frame_kind %0d",
                      rsp_kind, rsp_data_byte, rsp_byte_index, rsp_frame_kind);
               fail_count++;
            end else begin
               want = predicted_rsp.pop_front();
               check_field("kind", want.kind, rsp_kind);
               check_field("data_byte", want.data_byte, rsp_data_byte);
               check_field("byte_index", want.byte_index, rsp_byte_index);
               check_field("frame_kind", want.frame_kind, rsp_frame_kind);
            end
         end
         if (req_valid && req_ready)
            deframe_byte(req_rx_byte);
      end
   end

   // Watchdog: a long run of cycles without any transfer means the block is hung.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part on the reset configuration: loose bytes outside a frame, an
      // unknown type followed by a byte that must be ignored, short frames of the
      // second kind with a good and a bad checksum, and a frame cut by a restart.
      push_byte(8'h00);
      push_byte(8'hFF);
      push_byte(START_BYTE);
      push_byte(8'h00);
      push_byte(8'h05);
      push_byte(stray_code());
      push_byte(8'h44);
      queue_frame(code_b, 8'd3, 1'b1, 1'b1);
      queue_frame(code_b, 8'd2, 1'b0, 1'b1);
      push_byte(START_BYTE);
      push_byte(8'h00);
      push_byte(8'h09);
      push_byte(code_b);
      push_byte(8'h12);
      queue_frame(code_b, 8'd5, 1'b1, 1'b1);
      close_phase();

      // Extremes: zero header offset (offset bits above the field are dropped), the
      // widest offset, and no payload at all. A zero length makes the type byte the
      // checksum under the zero offset, and the longest frame that still ends before the
      // overlong cut saturates the reported length.
      program_all(8'h00, 8'hC0, 8'hFF, 8'h3F, 8'h00);
      queue_frame(code_a, 8'd0, 1'b1, 1'b1);
      queue_frame(code_a, 8'd254, 1'b1, 1'b1);
      queue_frame(code_b, 8'd0, 1'b1, 1'b1);
      run_traffic(30);

      // Both codes equal, so every match is the first kind; a small payload limit.
      program_all(8'h21, 8'd2, 8'h21, 8'd9, 8'd5);
      run_traffic(40);

      // Long stretch with no idling on either side.
      link_steady = 1'b1;
      program_all(RST_TYPE_A_CODE, 8'd32, RST_TYPE_B_CODE, 8'd3, 8'hFF);
      run_traffic(60);
      link_steady = 1'b0;

      program_random();
      run_traffic(40);
      program_random();
      run_traffic(40);

      program_all(8'h7F, 8'd3, 8'h80, 8'd32, 8'd1);
      run_traffic(30);

      if (fail_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

FILE: api_frame_deframer.f
rtl/core/afd_pkg.sv
rtl/core/api_frame_deframer.sv
verif/testbench.sv
